FILE: rtl/core/mfie_pkg.sv
// Shared constants, types and helper functions of the money flow indicator engine.
package mfie_pkg;

    localparam int MAX_WINDOW     = 256;
    localparam int DEFAULT_WINDOW = 21;

    localparam int SLOT_W   = $clog2(MAX_WINDOW);
    localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
    localparam int PRICE_W  = 32;
    localparam int VOL_W    = 32;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;
    localparam int MODE_W   = 2;
    localparam int WLEN_W   = 9;
    localparam int FRAC_W   = 16;

    localparam int FLOW_W = 50;
    localparam int FSUM_W = FLOW_W + SLOT_W;
    localparam int VSUM_W = VOL_W + SLOT_W;

    localparam int N_W    = PRICE_W + 2;
    localparam int PROD_W = N_W + VOL_W;
    localparam int NUM_W  = (PROD_W + FRAC_W > FSUM_W) ? PROD_W + FRAC_W : FSUM_W;
    localparam int DEN_W  = (VSUM_W > PRICE_W) ? VSUM_W : PRICE_W;
    localparam int DCNT_W = $clog2(NUM_W);
    localparam int MCNT_W = $clog2(VOL_W);

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [0:0] REG_MODE   = 1'b0;
    localparam logic [0:0] REG_WINDOW = 1'b1;

    localparam logic [MODE_W-1:0] MODE_AD       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WILLIAMS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CMF      = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_VOL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAT      = 2'd2;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] FLOW_LIM  =
        {{(VALUE_W-FLOW_W+1){1'b0}}, {(FLOW_W-1){1'b1}}};

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               sat;
    } sat_sum_t;

    typedef struct packed {
        logic [FLOW_W-1:0] flow;
        logic [VOL_W-1:0]  vol;
    } ring_entry_t;

    function automatic sat_sum_t sat_add(input logic signed [VALUE_W-1:0] a,
                                         input logic signed [VALUE_W-1:0] b);
        logic signed [VALUE_W:0] s;
        sat_sum_t r;
        s = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
        r.sat = s[VALUE_W] != s[VALUE_W-1];
        if (r.sat) begin
            r.value = s[VALUE_W] ? VALUE_MIN : VALUE_MAX;
        end else begin
            r.value = s[VALUE_W-1:0];
        end
        return r;
    endfunction

    // Clip the window register into 1..MAX_WINDOW.
    function automatic logic [CNT_W-1:0] win_eff(input logic [WLEN_W-1:0] wl);
        logic [CNT_W-1:0] w;
        if (wl == '0) begin
            w = CNT_W'(1);
        end else if (int'(wl) > MAX_WINDOW) begin
            w = CNT_W'(MAX_WINDOW);
        end else begin
            w = CNT_W'(wl);
        end
        return w;
    endfunction

endpackage

FILE: rtl/core/money_flow_indicator_engine_unit.sv
// Top level of the money flow indicator engine: bit-serial multiply, shared divider, ring.
//
// One price bar per request updates the accumulation/distribution line, the
// Williams A/D line and a ring of per-bar money flow volumes; the mode register
// picks which one is reported (mode 3 reports nothing). Bars are taken one at a
// time. A bar with nonzero range and volume passes through the one-bit-a-step
// multiplier and then the shift-subtract divider. Money flow mode adds a sweep
// of the window over the ring memory (one read port) and a second pass through
// the same divider. The result sits in an output register, so the next bar is
// taken while a result still waits. The ring memory needs no clearing after
// reset; only bars of the current series are summed. Write the registers only
// while idle.
module money_flow_indicator_engine_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mfie_pkg::ADDR_W-1:0]          paddr,
    input  logic [mfie_pkg::DATA_W-1:0]          pwdata,
    output logic [mfie_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [mfie_pkg::PRICE_W-1:0]         s_high_price,
    input  logic [mfie_pkg::PRICE_W-1:0]         s_low_price,
    input  logic [mfie_pkg::PRICE_W-1:0]         s_close_price,
    input  logic [mfie_pkg::VOL_W-1:0]           s_volume,
    input  logic                                 s_first_bar,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [mfie_pkg::VALUE_W-1:0]  m_value,
    output logic [mfie_pkg::STATUS_W-1:0]        m_status
);

    // Sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PREP  = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_DIV   = 4'd3;
    localparam logic [3:0] ST_LINE  = 4'd4;
    localparam logic [3:0] ST_SWEEP = 4'd5;
    localparam logic [3:0] ST_CMF   = 4'd6;
    localparam logic [3:0] ST_DIV2  = 4'd7;
    localparam logic [3:0] ST_EMIT  = 4'd8;

    localparam int SW = mfie_pkg::SLOT_W;
    localparam int CW = mfie_pkg::CNT_W;
    localparam int VW = mfie_pkg::VALUE_W;

    logic [3:0] state_reg;

    // Configuration
    logic [mfie_pkg::MODE_W-1:0] mode_reg;
    logic [mfie_pkg::WLEN_W-1:0] wlen_reg;

    // Bar held for the whole request
    logic [mfie_pkg::PRICE_W-1:0] hi_reg, lo_reg, cl_reg;
    logic [mfie_pkg::VOL_W-1:0]   vol_reg;

    // Series state
    logic signed [VW-1:0]          line_total_reg, will_total_reg;
    logic [mfie_pkg::PRICE_W-1:0]  prior_close_reg;
    logic                          have_prior_reg;
    logic [CW-1:0]                 bars_seen_reg;
    logic [SW-1:0]                 ring_slot_reg;

    logic will_valid_reg, will_sat_reg, flow_sat_reg, neg_reg;

    // Serial multiplier
    logic [mfie_pkg::N_W-1:0]    n_reg;
    logic [mfie_pkg::PROD_W-1:0] mul_reg;
    logic [mfie_pkg::MCNT_W-1:0] mul_cnt_reg;

    // Shared divider
    logic [mfie_pkg::NUM_W-1:0]  div_num_reg;
    logic [mfie_pkg::DEN_W-1:0]  div_rem_reg, div_den_reg;
    logic [mfie_pkg::DCNT_W-1:0] div_cnt_reg;

    // Window sweep
    logic signed [mfie_pkg::FSUM_W-1:0] fsum_reg;
    logic [mfie_pkg::VSUM_W-1:0]        vsum_reg;
    logic [SW-1:0]                      sweep_ptr_reg;
    logic [CW-1:0]                      issue_left_reg;
    logic                               rd_pend_reg;
    mfie_pkg::ring_entry_t              rd_q_reg;
    mfie_pkg::ring_entry_t              ring_mem [mfie_pkg::MAX_WINDOW];

    // Pending result and output register
    logic signed [VW-1:0]          res_value_reg;
    logic [mfie_pkg::STATUS_W-1:0] res_status_reg;
    logic                          m_valid_reg;
    logic signed [VW-1:0]          m_value_reg;
    logic [mfie_pkg::STATUS_W-1:0] m_status_reg;

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    logic cfg_we;
    assign cfg_we = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == mfie_pkg::REG_WINDOW) ?
                    mfie_pkg::DATA_W'(wlen_reg) : mfie_pkg::DATA_W'(mode_reg);

    // ---------------------------------------------------------------
    // Bar preparation: signed range and numerator magnitudes
    // ---------------------------------------------------------------
    logic signed [mfie_pkg::PRICE_W:0]   rng;
    logic signed [mfie_pkg::PRICE_W+2:0] pos;
    logic [mfie_pkg::PRICE_W+2:0]        pos_abs;
    logic [mfie_pkg::PRICE_W:0]          rng_abs;
    logic                                no_flow;

    always_comb begin
        rng = $signed({1'b0, hi_reg}) - $signed({1'b0, lo_reg});
        pos = $signed({2'b00, cl_reg, 1'b0}) - $signed({3'b000, lo_reg})
              - $signed({3'b000, hi_reg});
        pos_abs = pos[mfie_pkg::PRICE_W+2] ? -pos : pos;
        rng_abs = rng[mfie_pkg::PRICE_W] ? -rng : rng;
        no_flow = (vol_reg == '0) || (hi_reg == lo_reg);
    end

    // Williams step against the prior close
    logic [mfie_pkg::PRICE_W-1:0] w_hi, w_lo;
    logic signed [VW-1:0]         w_delta;
    mfie_pkg::sat_sum_t           w_sum;

    always_comb begin
        w_hi = (hi_reg > prior_close_reg) ? hi_reg : prior_close_reg;
        w_lo = (lo_reg < prior_close_reg) ? lo_reg : prior_close_reg;
        if (cl_reg > prior_close_reg) begin
            w_delta = VW'(cl_reg - w_lo);
        end else if (cl_reg < prior_close_reg) begin
            w_delta = -VW'(w_hi - cl_reg);
        end else begin
            w_delta = '0;
        end
        w_sum = mfie_pkg::sat_add(will_total_reg, w_delta);
    end

    // ---------------------------------------------------------------
    // Multiplier and divider steps
    // ---------------------------------------------------------------
    logic [mfie_pkg::N_W:0]      mul_sum;
    logic [mfie_pkg::PROD_W-1:0] mul_step;

    always_comb begin
        mul_sum  = {1'b0, mul_reg[mfie_pkg::PROD_W-1:mfie_pkg::VOL_W]} +
                   (mul_reg[0] ? {1'b0, n_reg} : '0);
        mul_step = {mul_sum, mul_reg[mfie_pkg::VOL_W-1:1]};
    end

    logic [mfie_pkg::DEN_W+1:0] div_diff;
    logic                       div_ge;
    logic [mfie_pkg::DEN_W-1:0] div_rem_step;
    logic [mfie_pkg::NUM_W-1:0] div_num_step;

    always_comb begin
        div_diff = {1'b0, div_rem_reg, div_num_reg[mfie_pkg::NUM_W-1]}
                   - {2'b00, div_den_reg};
        div_ge   = !div_diff[mfie_pkg::DEN_W+1];
        div_rem_step = div_ge ? div_diff[mfie_pkg::DEN_W-1:0] :
                       {div_rem_reg[mfie_pkg::DEN_W-2:0], div_num_reg[mfie_pkg::NUM_W-1]};
        div_num_step = {div_num_reg[mfie_pkg::NUM_W-2:0], div_ge};
    end

    // ---------------------------------------------------------------
    // Line update from the flow quotient
    // ---------------------------------------------------------------
    logic                 mag_cap;
    logic [VW-2:0]        mag;
    logic signed [VW-1:0] mfv, ring_flow;
    logic                 ring_clip;
    mfie_pkg::sat_sum_t   line_sum;
    mfie_pkg::ring_entry_t wr_entry;
    logic [SW-1:0]        slot_next;
    logic [CW-1:0]        bars_next;
    logic [CW-1:0]        win;

    always_comb begin
        mag_cap = |div_num_reg[mfie_pkg::NUM_W-1:VW-1];
        mag     = mag_cap ? {(VW-1){1'b1}} : div_num_reg[VW-2:0];
        mfv     = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        line_sum = mfie_pkg::sat_add(line_total_reg, mfv);
        ring_clip = 1'b0;
        ring_flow = mfv;
        if (mfv > mfie_pkg::FLOW_LIM) begin
            ring_flow = mfie_pkg::FLOW_LIM;
            ring_clip = 1'b1;
        end else if (mfv < -mfie_pkg::FLOW_LIM) begin
            ring_flow = -mfie_pkg::FLOW_LIM;
            ring_clip = 1'b1;
        end
        wr_entry.flow = ring_flow[mfie_pkg::FLOW_W-1:0];
        wr_entry.vol  = vol_reg;
        slot_next = (ring_slot_reg == SW'(mfie_pkg::MAX_WINDOW - 1)) ?
                    '0 : ring_slot_reg + 1'b1;
        bars_next = (bars_seen_reg < CW'(mfie_pkg::MAX_WINDOW)) ?
                    bars_seen_reg + 1'b1 : bars_seen_reg;
        win = mfie_pkg::win_eff(wlen_reg);
    end

    // ---------------------------------------------------------------
    // Ring memory: one write port, one registered read port
    // ---------------------------------------------------------------
    logic          mem_we, mem_re;
    logic [SW-1:0] rd_addr;

    assign mem_we  = (state_reg == ST_LINE);
    assign mem_re  = (state_reg == ST_SWEEP) && (issue_left_reg != '0);
    assign rd_addr = (sweep_ptr_reg == '0) ? SW'(mfie_pkg::MAX_WINDOW - 1) :
                     sweep_ptr_reg - 1'b1;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[ring_slot_reg] <= wr_entry;
        end
        if (mem_re) begin
            rd_q_reg <= ring_mem[rd_addr];
        end
    end

    logic [mfie_pkg::FSUM_W-1:0] fsum_abs;
    logic [63:0]                 cmf_q;
    assign fsum_abs = fsum_reg[mfie_pkg::FSUM_W-1] ? -fsum_reg : fsum_reg;
    assign cmf_q    = div_num_step[63:0];

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    // ---------------------------------------------------------------
    // Sequencer and datapath
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            mode_reg        <= mfie_pkg::MODE_AD;
            wlen_reg        <= mfie_pkg::WLEN_W'(mfie_pkg::DEFAULT_WINDOW);
            line_total_reg  <= '0;
            will_total_reg  <= '0;
            prior_close_reg <= '0;
            have_prior_reg  <= 1'b0;
            bars_seen_reg   <= '0;
            ring_slot_reg   <= '0;
            m_valid_reg     <= 1'b0;
            rd_pend_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (paddr[2] == mfie_pkg::REG_MODE) begin
                    mode_reg <= pwdata[mfie_pkg::MODE_W-1:0];
                end else begin
                    wlen_reg <= pwdata[mfie_pkg::WLEN_W-1:0];
                end
            end

            // drop the result once taken; a new one is loaded from ST_EMIT
            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg  <= 1'b1;
                m_value_reg  <= res_value_reg;
                m_status_reg <= res_status_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        hi_reg  <= s_high_price;
                        lo_reg  <= s_low_price;
                        cl_reg  <= s_close_price;
                        vol_reg <= s_volume;
                        if (s_first_bar) begin
                            line_total_reg  <= '0;
                            will_total_reg  <= '0;
                            prior_close_reg <= '0;
                            have_prior_reg  <= 1'b0;
                            bars_seen_reg   <= '0;
                            ring_slot_reg   <= '0;
                        end
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    will_valid_reg <= have_prior_reg;
                    will_sat_reg   <= have_prior_reg && w_sum.sat;
                    if (have_prior_reg) begin
                        will_total_reg <= w_sum.value;
                    end
                    prior_close_reg <= cl_reg;
                    have_prior_reg  <= 1'b1;
                    if (no_flow) begin
                        div_num_reg <= '0;
                        neg_reg     <= 1'b0;
                        state_reg   <= ST_LINE;
                    end else begin
                        neg_reg     <= pos[mfie_pkg::PRICE_W+2] ^ rng[mfie_pkg::PRICE_W];
                        n_reg       <= pos_abs[mfie_pkg::N_W-1:0];
                        div_den_reg <= mfie_pkg::DEN_W'(rng_abs[mfie_pkg::PRICE_W-1:0]);
                        mul_reg     <= mfie_pkg::PROD_W'(vol_reg);
                        mul_cnt_reg <= '0;
                        state_reg   <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    mul_reg     <= mul_step;
                    mul_cnt_reg <= mul_cnt_reg + 1'b1;
                    if (mul_cnt_reg == mfie_pkg::MCNT_W'(mfie_pkg::VOL_W - 1)) begin
                        div_num_reg <= mfie_pkg::NUM_W'({mul_step, {mfie_pkg::FRAC_W{1'b0}}});
                        div_rem_reg <= '0;
                        div_cnt_reg <= '0;
                        state_reg   <= ST_DIV;
                    end
                end
                ST_DIV, ST_DIV2: begin
                    div_num_reg <= div_num_step;
                    div_rem_reg <= div_rem_step;
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == mfie_pkg::DCNT_W'(mfie_pkg::NUM_W - 1)) begin
                        if (state_reg == ST_DIV) begin
                            state_reg <= ST_LINE;
                        end else begin
                            res_value_reg  <= neg_reg ? -$signed(cmf_q) : $signed(cmf_q);
                            res_status_reg <= flow_sat_reg ? mfie_pkg::STATUS_SAT :
                                                             mfie_pkg::STATUS_OK;
                            state_reg      <= ST_EMIT;
                        end
                    end
                end
                ST_LINE: begin
                    line_total_reg <= line_sum.value;
                    flow_sat_reg   <= ring_clip;
                    ring_slot_reg  <= slot_next;
                    bars_seen_reg  <= bars_next;
                    case (mode_reg)
                        mfie_pkg::MODE_AD: begin
                            res_value_reg  <= line_sum.value;
                            res_status_reg <= (mag_cap || line_sum.sat) ?
                                              mfie_pkg::STATUS_SAT : mfie_pkg::STATUS_OK;
                            state_reg      <= ST_EMIT;
                        end
                        mfie_pkg::MODE_WILLIAMS: begin
                            res_value_reg  <= will_total_reg;
                            res_status_reg <= will_sat_reg ? mfie_pkg::STATUS_SAT :
                                                             mfie_pkg::STATUS_OK;
                            state_reg      <= will_valid_reg ? ST_EMIT : ST_IDLE;
                        end
                        mfie_pkg::MODE_CMF: begin
                            fsum_reg       <= '0;
                            vsum_reg       <= '0;
                            sweep_ptr_reg  <= slot_next;
                            issue_left_reg <= win;
                            rd_pend_reg    <= 1'b0;
                            state_reg      <= (bars_next >= win) ? ST_SWEEP : ST_IDLE;
                        end
                        default: begin
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end
                ST_SWEEP: begin
                    rd_pend_reg <= mem_re;
                    if (mem_re) begin
                        sweep_ptr_reg  <= rd_addr;
                        issue_left_reg <= issue_left_reg - 1'b1;
                    end
                    if (rd_pend_reg) begin
                        fsum_reg <= fsum_reg + $signed({
                            {(mfie_pkg::FSUM_W-mfie_pkg::FLOW_W){rd_q_reg.flow[mfie_pkg::FLOW_W-1]}},
                            rd_q_reg.flow});
                        vsum_reg <= vsum_reg + mfie_pkg::VSUM_W'(rd_q_reg.vol);
                    end
                    if (!mem_re && !rd_pend_reg) begin
                        state_reg <= ST_CMF;
                    end
                end
                ST_CMF: begin
                    if (vsum_reg == '0) begin
                        res_value_reg  <= '0;
                        res_status_reg <= mfie_pkg::STATUS_ZERO_VOL;
                        state_reg      <= ST_EMIT;
                    end else begin
                        div_num_reg <= mfie_pkg::NUM_W'(fsum_abs);
                        div_den_reg <= mfie_pkg::DEN_W'(vsum_reg);
                        div_rem_reg <= '0;
                        div_cnt_reg <= '0;
                        neg_reg     <= fsum_reg[mfie_pkg::FSUM_W-1];
                        state_reg   <= ST_DIV2;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;

endmodule

FILE: rtl/core/mfie_checker.sv
// Port-level checks of the money flow indicator engine, bound to the top level.
module mfie_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [mfie_pkg::VALUE_W-1:0] m_value,
    input logic [mfie_pkg::STATUS_W-1:0]       m_status
);

    // Hold a stalled result unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_status))
        else $error("stalled result changed");

    // A zero volume sum always reports value zero.
    a_zero_vol: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == mfie_pkg::STATUS_ZERO_VOL |-> m_value == '0)
        else $error("zero volume status with nonzero value");

    // Status never carries the unused code.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == mfie_pkg::STATUS_OK
                 || m_status == mfie_pkg::STATUS_ZERO_VOL
                 || m_status == mfie_pkg::STATUS_SAT)
        else $error("bad status code");

    // Drop ready right after a request is taken; bars go one at a time.
    a_one_bar: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready held after an accepted request");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result present after reset");

endmodule

bind money_flow_indicator_engine_unit mfie_checker u_mfie_checker (.*);
